>>> rtl/tcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm_pkg
// Shared types and constants of the touch coordinate mapper: register
// indexes, mode bit positions, reset values and the control word of the
// pipeline.
// ----------------------------------------------------------------------------
package tcm_pkg;

   localparam int RAW_BITS_DEF    = 12;
   localparam int SCREEN_BITS_DEF = 12;
   localparam int CSR_ADDR_W      = 3;
   localparam int MODE_W          = 4;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_MODE_FLAGS    = 3'd0,
      REG_RAW_X_LOW     = 3'd1,
      REG_RAW_X_HIGH    = 3'd2,
      REG_RAW_Y_LOW     = 3'd3,
      REG_RAW_Y_HIGH    = 3'd4,
      REG_SCREEN_WIDTH  = 3'd5,
      REG_SCREEN_HEIGHT = 3'd6
   } reg_index_type;

   // Bit positions in the mode register.
   localparam int MODE_VALID    = 0;
   localparam int MODE_SWAP     = 1;
   localparam int MODE_MIRROR_X = 2;
   localparam int MODE_MIRROR_Y = 3;

   // Reset values of the registers.
   localparam int RAW_LOW_RST       = 200;
   localparam int RAW_HIGH_RST      = 3900;
   localparam int SCREEN_WIDTH_RST  = 320;
   localparam int SCREEN_HEIGHT_RST = 240;

   // Control word that travels alongside the data of each item.
   typedef struct packed {
      logic valid;
      logic ok;
   } ctl_type;

endpackage

>>> rtl/tcm_axis_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm_axis_front
// Front of one axis: mirror and clamp into the raw window, offset from the
// low edge, then scale by (size - 1), or by zero for a size of zero. Two register stages.
// ----------------------------------------------------------------------------
module tcm_axis_front #(
   parameter int RAW_BITS    = tcm_pkg::RAW_BITS_DEF,
   parameter int SCREEN_BITS = tcm_pkg::SCREEN_BITS_DEF
) (
   input  logic                          clock,
   input  logic [RAW_BITS-1:0]           raw_value,
   input  logic [RAW_BITS-1:0]           raw_low,
   input  logic [RAW_BITS-1:0]           raw_high,
   input  logic                          mirror,
   input  logic [SCREEN_BITS-1:0]        screen_size,
   output logic [RAW_BITS+SCREEN_BITS-1:0] product,
   output logic [RAW_BITS-1:0]           span
);

   localparam int W      = RAW_BITS + 2;
   localparam int PROD_W = RAW_BITS + SCREEN_BITS;

   logic signed [W-1:0]       v_s, lo_s, hi_s, vm_s, vc_s, d_s;
   logic [RAW_BITS-1:0]       offset_in, offset_ff;
   logic [RAW_BITS-1:0]       span_in, span_a_ff, span_b_ff;
   logic [SCREEN_BITS-1:0]    top_in, top_ff;
   logic [PROD_W-1:0]         product_in, product_ff;

   always_comb begin
      v_s  = $signed({2'b00, raw_value});
      lo_s = $signed({2'b00, raw_low});
      hi_s = $signed({2'b00, raw_high});
      // Mirroring reflects the reading about the center of the window.
      if (mirror) begin
         vm_s = hi_s + lo_s - v_s;
      end else begin
         vm_s = v_s;
      end
      vc_s = vm_s;
      if (vc_s < lo_s) begin
         vc_s = lo_s;
      end
      if (vc_s > hi_s) begin
         vc_s = hi_s;
      end
      d_s       = vc_s - lo_s;
      offset_in = d_s[RAW_BITS-1:0];
      span_in   = raw_high - raw_low;
      if (screen_size == '0) begin
         top_in = '0;
      end else begin
         top_in = screen_size - SCREEN_BITS'(1);
      end
      product_in = PROD_W'(offset_ff) * PROD_W'(top_ff);
   end

   always_ff @(posedge clock) begin
      offset_ff  <= offset_in;
      span_a_ff  <= span_in;
      top_ff     <= top_in;
      product_ff <= product_in;
      span_b_ff  <= span_a_ff;
   end

   assign product = product_ff;
   assign span    = span_b_ff;

endmodule

>>> rtl/tcm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm_divider
// Pipelined restoring divider: one quotient bit per register stage. The
// quotient is known to fit SCREEN_BITS bits because the dividend is at most
// span * (size - 1).
// ----------------------------------------------------------------------------
module tcm_divider #(
   parameter int RAW_BITS    = tcm_pkg::RAW_BITS_DEF,
   parameter int SCREEN_BITS = tcm_pkg::SCREEN_BITS_DEF
) (
   input  logic                            clock,
   input  logic [RAW_BITS+SCREEN_BITS-1:0] dividend,
   input  logic [RAW_BITS-1:0]             divisor,
   output logic [SCREEN_BITS-1:0]          quotient
);

   localparam int R = RAW_BITS;
   localparam int Q = SCREEN_BITS;

   logic [R-1:0] rem_ff  [Q];
   logic [Q-1:0] low_ff  [Q];
   logic [Q-1:0] quot_ff [Q];
   logic [R-1:0] div_ff  [Q];

   for (genvar k = 0; k < Q; k++) begin : g_step
      logic [R-1:0] rem_src;
      logic [Q-1:0] low_src;
      logic [Q-1:0] quot_src;
      logic [R-1:0] div_src;
      logic [R:0]   trial;
      logic [R:0]   diff;
      logic [R-1:0] rem_in;
      logic [Q-1:0] low_in;
      logic [Q-1:0] quot_in;

      if (k == 0) begin : g_first
         // The upper bits of the dividend are already below the divisor.
         assign rem_src  = dividend[R+Q-1:Q];
         assign low_src  = dividend[Q-1:0];
         assign quot_src = '0;
         assign div_src  = divisor;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign low_src  = low_ff[k-1];
         assign quot_src = quot_ff[k-1];
         assign div_src  = div_ff[k-1];
      end

      always_comb begin
         trial  = {rem_src, low_src[Q-1]};
         diff   = trial - {1'b0, div_src};
         low_in = {low_src[Q-2:0], 1'b0};
         if (trial >= {1'b0, div_src}) begin
            rem_in  = diff[R-1:0];
            quot_in = {quot_src[Q-2:0], 1'b1};
         end else begin
            rem_in  = trial[R-1:0];
            quot_in = {quot_src[Q-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         low_ff[k]  <= low_in;
         quot_ff[k] <= quot_in;
         div_ff[k]  <= div_src;
      end
   end

   assign quotient = quot_ff[Q-1];

endmodule

>>> rtl/touch_coordinate_mapper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_coordinate_mapper_core
// Linear touchscreen calibration: maps one raw touch sample to a pixel.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle; busy is high only during
// reset. Each item passes two front stages (clamp, multiply), then the
// divider, which resolves one quotient bit per pipeline stage, then the
// output register. Each result is shown for one cycle on rsp_valid and
// cannot be held off. Configuration must only be written while no item is
// in flight.
module touch_coordinate_mapper_core #(
   parameter int RAW_BITS    = tcm_pkg::RAW_BITS_DEF,
   parameter int SCREEN_BITS = tcm_pkg::SCREEN_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [RAW_BITS-1:0]                   req_raw_x,
   input  logic [RAW_BITS-1:0]                   req_raw_y,
   output logic                                  rsp_valid,
   output logic                                  rsp_mapped_ok,
   output logic [SCREEN_BITS-1:0]                rsp_screen_x,
   output logic [SCREEN_BITS-1:0]                rsp_screen_y,
   input  logic                                  csr_we,
   input  logic [tcm_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [((RAW_BITS > SCREEN_BITS) ? RAW_BITS : SCREEN_BITS)-1:0] csr_wdata
);

   localparam int DEPTH = SCREEN_BITS + 2;

   logic [tcm_pkg::MODE_W-1:0] mode_ff;
   logic [RAW_BITS-1:0]        x_low_ff, x_high_ff, y_low_ff, y_high_ff;
   logic [SCREEN_BITS-1:0]     width_ff, height_ff;

   logic                       accept;
   logic [RAW_BITS-1:0]        axis_x, axis_y;
   tcm_pkg::ctl_type           ctl_in;
   tcm_pkg::ctl_type           ctl_ff [DEPTH];

   logic [RAW_BITS+SCREEN_BITS-1:0] prod_x, prod_y;
   logic [RAW_BITS-1:0]             span_x, span_y;
   logic [SCREEN_BITS-1:0]          quot_x, quot_y;

   logic                       rsp_valid_in, rsp_valid_ff;
   logic                       rsp_ok_in, rsp_ok_ff;
   logic [SCREEN_BITS-1:0]     rsp_x_in, rsp_x_ff, rsp_y_in, rsp_y_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= '0;
         x_low_ff  <= RAW_BITS'(tcm_pkg::RAW_LOW_RST);
         x_high_ff <= RAW_BITS'(tcm_pkg::RAW_HIGH_RST);
         y_low_ff  <= RAW_BITS'(tcm_pkg::RAW_LOW_RST);
         y_high_ff <= RAW_BITS'(tcm_pkg::RAW_HIGH_RST);
         width_ff  <= SCREEN_BITS'(tcm_pkg::SCREEN_WIDTH_RST);
         height_ff <= SCREEN_BITS'(tcm_pkg::SCREEN_HEIGHT_RST);
      end else if (csr_we) begin
         case (csr_addr)
            tcm_pkg::REG_MODE_FLAGS:    mode_ff   <= csr_wdata[tcm_pkg::MODE_W-1:0];
            tcm_pkg::REG_RAW_X_LOW:     x_low_ff  <= csr_wdata[RAW_BITS-1:0];
            tcm_pkg::REG_RAW_X_HIGH:    x_high_ff <= csr_wdata[RAW_BITS-1:0];
            tcm_pkg::REG_RAW_Y_LOW:     y_low_ff  <= csr_wdata[RAW_BITS-1:0];
            tcm_pkg::REG_RAW_Y_HIGH:    y_high_ff <= csr_wdata[RAW_BITS-1:0];
            tcm_pkg::REG_SCREEN_WIDTH:  width_ff  <= csr_wdata[SCREEN_BITS-1:0];
            tcm_pkg::REG_SCREEN_HEIGHT: height_ff <= csr_wdata[SCREEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (mode_ff[tcm_pkg::MODE_SWAP]) begin
         axis_x = req_raw_y;
         axis_y = req_raw_x;
      end else begin
         axis_x = req_raw_x;
         axis_y = req_raw_y;
      end
      ctl_in.valid = accept;
      ctl_in.ok    = mode_ff[tcm_pkg::MODE_VALID] && (x_high_ff > x_low_ff)
                     && (y_high_ff > y_low_ff);
   end

   tcm_axis_front #(.RAW_BITS(RAW_BITS), .SCREEN_BITS(SCREEN_BITS)) u_front_x (
      .clock      (clock),
      .raw_value  (axis_x),
      .raw_low    (x_low_ff),
      .raw_high   (x_high_ff),
      .mirror     (mode_ff[tcm_pkg::MODE_MIRROR_X]),
      .screen_size(width_ff),
      .product    (prod_x),
      .span       (span_x)
   );

   tcm_axis_front #(.RAW_BITS(RAW_BITS), .SCREEN_BITS(SCREEN_BITS)) u_front_y (
      .clock      (clock),
      .raw_value  (axis_y),
      .raw_low    (y_low_ff),
      .raw_high   (y_high_ff),
      .mirror     (mode_ff[tcm_pkg::MODE_MIRROR_Y]),
      .screen_size(height_ff),
      .product    (prod_y),
      .span       (span_y)
   );

   tcm_divider #(.RAW_BITS(RAW_BITS), .SCREEN_BITS(SCREEN_BITS)) u_div_x (
      .clock   (clock),
      .dividend(prod_x),
      .divisor (span_x),
      .quotient(quot_x)
   );

   tcm_divider #(.RAW_BITS(RAW_BITS), .SCREEN_BITS(SCREEN_BITS)) u_div_y (
      .clock   (clock),
      .dividend(prod_y),
      .divisor (span_y),
      .quotient(quot_y)
   );

   // Control line that moves in step with the data stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            ctl_ff[i] <= '0;
         end
      end else begin
         ctl_ff[0] <= ctl_in;
         for (int i = 1; i < DEPTH; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   // An item that fails the calibration check reports zero coordinates.
   always_comb begin
      rsp_valid_in = ctl_ff[DEPTH-1].valid;
      rsp_ok_in    = ctl_ff[DEPTH-1].valid && ctl_ff[DEPTH-1].ok;
      rsp_x_in     = rsp_ok_in ? quot_x : '0;
      rsp_y_in     = rsp_ok_in ? quot_y : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_ok_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rsp_ok_ff    <= rsp_ok_in;
      end
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mapped_ok = rsp_ok_ff;
   assign rsp_screen_x  = rsp_x_ff;
   assign rsp_screen_y  = rsp_y_ff;

   // Every accepted item produces a result exactly at the pipeline latency.
   a_item_out: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##(DEPTH) rsp_valid_ff)
      else $error("accepted item did not produce a result on time");

   // No result appears without an item taken at the matching cycle.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(accept, DEPTH + 1))
      else $error("result without a matching item");

   // A rejected mapping reports zero coordinates.
   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> (rsp_x_ff == '0) && (rsp_y_ff == '0))
      else $error("nonzero coordinates on a failed mapping");

   // The ok flag is only raised on a result cycle.
   a_ok_with_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_ok_ff |-> rsp_valid_ff)
      else $error("mapped_ok outside a result cycle");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for touch_coordinate_mapper_core. A directed table
// runs under the reset windows with a range of mode words; then each of a
// series of calibration settings (full range, tiny, empty and inverted
// windows, zero screen sizes, random ones) carries random touch samples.
// Each item is checked against its table result or an in-bench pixel mapper.
// ----------------------------------------------------------------------------
module tb;

   localparam int LATENCY        = tcm_pkg::SCREEN_BITS_DEF + 3;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int N_FIXED        = 6;
   localparam int N_PHASES       = 20;
   localparam int SAMPLES_PER_SET = 80;
   localparam int RAW_MAX        = (1 << tcm_pkg::RAW_BITS_DEF) - 1;

   // The block defines no register at this index; writes to it must be dropped.
   localparam logic [tcm_pkg::CSR_ADDR_W-1:0] REG_SPARE = 3'd7;

   typedef logic [tcm_pkg::RAW_BITS_DEF-1:0]    raw_type;
   typedef logic [tcm_pkg::SCREEN_BITS_DEF-1:0] screen_type;
   typedef logic [((tcm_pkg::RAW_BITS_DEF > tcm_pkg::SCREEN_BITS_DEF) ?
                   tcm_pkg::RAW_BITS_DEF : tcm_pkg::SCREEN_BITS_DEF)-1:0]
      csr_data_type;

   typedef struct packed {
      logic       ok;
      screen_type sx;
      screen_type sy;
   } pixel_type;

   typedef struct packed {
      logic [tcm_pkg::MODE_W-1:0] mode;
      raw_type                    x_low;
      raw_type                    x_high;
      raw_type                    y_low;
      raw_type                    y_high;
      screen_type                 width;
      screen_type                 height;
   } calib_type;

   typedef struct packed {
      csr_data_type mode;
      raw_type      x;
      raw_type      y;
      logic         typed;
      pixel_type    res;
   } touch_row_type;

   typedef struct packed {
      csr_data_type mode;
      raw_type      x_low;
      raw_type      x_high;
      raw_type      y_low;
      raw_type      y_high;
      screen_type   width;
      screen_type   height;
      logic         spare;
   } calib_set_type;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   raw_type      req_raw_x;
   raw_type      req_raw_y;
   logic         rsp_valid;
   logic         rsp_mapped_ok;
   screen_type   rsp_screen_x;
   screen_type   rsp_screen_y;
   logic         csr_we;
   logic [tcm_pkg::CSR_ADDR_W-1:0] csr_addr;
   csr_data_type csr_wdata;

   calib_type    calib;
   pixel_type    pending_pixels[$];
   int           error_count;
   int           idle_cycles;
   bit           burst_mode;

   // Directed rows run under the reset windows: x 200..3900 onto 0..319,
   // y 200..3900 onto 0..239.
   touch_row_type touch_rows[18] = '{
      '{12'h000,    12'd0,    12'd0, 1'b1, '{1'b0, 12'd0,   12'd0}},
      '{12'h000, 12'd4095, 12'd4095, 1'b1, '{1'b0, 12'd0,   12'd0}},
      '{12'h001,    12'd0,    12'd0, 1'b1, '{1'b1, 12'd0,   12'd0}},
      '{12'h001, 12'd4095, 12'd4095, 1'b1, '{1'b1, 12'd319, 12'd239}},
      '{12'h001,  12'd200, 12'd3900, 1'b1, '{1'b1, 12'd0,   12'd239}},
      '{12'h001, 12'd3900,  12'd200, 1'b1, '{1'b1, 12'd319, 12'd0}},
      '{12'h001, 12'd2050, 12'd1000, 1'b0, '{1'b0, 12'd0,   12'd0}},
      '{12'h001, 12'd4095,    12'd0, 1'b1, '{1'b1, 12'd319, 12'd0}},
      '{12'h003, 12'd4095,    12'd0, 1'b1, '{1'b1, 12'd0,   12'd239}},
      '{12'h003, 12'd1234, 12'd2345, 1'b0, '{1'b0, 12'd0,   12'd0}},
      '{12'h005,    12'd0,    12'd0, 1'b1, '{1'b1, 12'd319, 12'd0}},
      '{12'h005, 12'd4095, 12'd4095, 1'b1, '{1'b1, 12'd0,   12'd239}},
      '{12'h009,    12'd0,    12'd0, 1'b1, '{1'b1, 12'd0,   12'd239}},
      '{12'h00F,    12'd0, 12'd4095, 1'b1, '{1'b1, 12'd0,   12'd239}},
      '{12'h00F, 12'd1500, 12'd2600, 1'b0, '{1'b0, 12'd0,   12'd0}},
      '{12'h00E, 12'd1000, 12'd1000, 1'b1, '{1'b0, 12'd0,   12'd0}},
      '{12'hFF1, 12'd4095, 12'd4095, 1'b1, '{1'b1, 12'd319, 12'd239}},
      '{12'hAAB, 12'd3000,  12'd500, 1'b0, '{1'b0, 12'd0,   12'd0}}
   };

   // Fixed calibration sets: full range, one-count windows with one-pixel
   // screens, an empty x window, an inverted y window, zero screen sizes,
   // and a mode word with junk in its upper bits.
   calib_set_type fixed_sets[N_FIXED] = '{
      '{12'h001,    12'd0, 12'd4095,    12'd0, 12'd4095, 12'd4095, 12'd4095, 1'b0},
      '{12'h00F, 12'd4094, 12'd4095,    12'd0,    12'd1,    12'd1,    12'd1, 1'b0},
      '{12'h001, 12'd2000, 12'd2000,  12'd100, 12'd3000,  12'd640,  12'd480, 1'b1},
      '{12'h003,  12'd100, 12'd3000, 12'd3000,  12'd100,  12'd640,  12'd480, 1'b0},
      '{12'h00F,  12'd300, 12'd3800,  12'd250, 12'd3700,    12'd0,    12'd0, 1'b0},
      '{12'hFF7,    12'd0, 12'd4095,    12'd0, 12'd4095, 12'd4095,    12'd1, 1'b1}
   };

   touch_coordinate_mapper_core DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_raw_x     (req_raw_x),
      .req_raw_y     (req_raw_y),
      .rsp_valid     (rsp_valid),
      .rsp_mapped_ok (rsp_mapped_ok),
      .rsp_screen_x  (rsp_screen_x),
      .rsp_screen_y  (rsp_screen_y),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic screen_type scale_axis(int v, int lo, int hi, bit mirror, int size);
      int top;
      int q;
      if (mirror) v = hi + lo - v;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      top = (size == 0) ? 0 : size - 1;
      q = ((v - lo) * top) / (hi - lo);
      if (q > top) q = top;
      return screen_type'(q);
   endfunction

   function automatic pixel_type map_touch(raw_type rx, raw_type ry);
      pixel_type px;
      raw_type   ax;
      raw_type   ay;
      px = '0;
      if (!calib.mode[tcm_pkg::MODE_VALID] || calib.x_high <= calib.x_low ||
          calib.y_high <= calib.y_low)
         return px;
      ax = calib.mode[tcm_pkg::MODE_SWAP] ? ry : rx;
      ay = calib.mode[tcm_pkg::MODE_SWAP] ? rx : ry;
      px.ok = 1'b1;
      px.sx = scale_axis(int'(ax), int'(calib.x_low), int'(calib.x_high),
                         calib.mode[tcm_pkg::MODE_MIRROR_X], int'(calib.width));
      px.sy = scale_axis(int'(ay), int'(calib.y_low), int'(calib.y_high),
                         calib.mode[tcm_pkg::MODE_MIRROR_Y], int'(calib.height));
      return px;
   endfunction

   function automatic void track_csr_write(logic [tcm_pkg::CSR_ADDR_W-1:0] idx,
                                           csr_data_type data);
      case (idx)
         tcm_pkg::REG_MODE_FLAGS:    calib.mode   = data[tcm_pkg::MODE_W-1:0];
         tcm_pkg::REG_RAW_X_LOW:     calib.x_low  = data[tcm_pkg::RAW_BITS_DEF-1:0];
         tcm_pkg::REG_RAW_X_HIGH:    calib.x_high = data[tcm_pkg::RAW_BITS_DEF-1:0];
         tcm_pkg::REG_RAW_Y_LOW:     calib.y_low  = data[tcm_pkg::RAW_BITS_DEF-1:0];
         tcm_pkg::REG_RAW_Y_HIGH:    calib.y_high = data[tcm_pkg::RAW_BITS_DEF-1:0];
         tcm_pkg::REG_SCREEN_WIDTH:  calib.width  = data[tcm_pkg::SCREEN_BITS_DEF-1:0];
         tcm_pkg::REG_SCREEN_HEIGHT: calib.height = data[tcm_pkg::SCREEN_BITS_DEF-1:0];
         default: ;
      endcase
   endfunction

   // Raw readings lean toward the window edges and the ends of the raw range.
   function automatic raw_type pick_raw(raw_type lo, raw_type hi);
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom_range(0, RAW_MAX);
         4: v = 0;
         5: v = RAW_MAX;
         6: v = int'(lo) + $urandom_range(0, 4) - 2;
         7: v = int'(hi) + $urandom_range(0, 4) - 2;
         default: v = $urandom_range(int'(lo), int'(hi));
      endcase
      return raw_type'(v);
   endfunction

   function automatic void pick_window(output raw_type lo, output raw_type hi);
      case ($urandom_range(0, 9))
         0: begin
            lo = raw_type'($urandom_range(0, RAW_MAX));
            hi = lo;
         end
         1: begin
            lo = raw_type'($urandom_range(0, RAW_MAX));
            hi = raw_type'($urandom_range(0, RAW_MAX));
         end
         default: begin
            lo = raw_type'($urandom_range(0, RAW_MAX - 1));
            hi = raw_type'($urandom_range(int'(lo) + 1, RAW_MAX));
         end
      endcase
   endfunction

   function automatic screen_type pick_size();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 12'd1;
         2: return 12'd4095;
         default: return screen_type'($urandom_range(1, 4095));
      endcase
   endfunction

   function automatic calib_set_type random_set();
      calib_set_type s;
      s.mode = csr_data_type'($urandom_range(0, 4095));
      s.mode[tcm_pkg::MODE_VALID] = ($urandom_range(0, 9) != 0);
      pick_window(s.x_low, s.x_high);
      pick_window(s.y_low, s.y_high);
      s.width  = pick_size();
      s.height = pick_size();
      s.spare  = ($urandom_range(0, 3) == 0);
      return s;
   endfunction

   task automatic send_touch(raw_type rx, raw_type ry, bit typed, pixel_type typed_res);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start     <= 1'b1;
      req_raw_x <= rx;
      req_raw_y <= ry;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_pixels.push_back(typed ? typed_res : map_touch(rx, ry));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [tcm_pkg::CSR_ADDR_W-1:0] idx, csr_data_type data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      track_csr_write(idx, data);
   endtask

   task automatic csr_done();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_calibration(calib_set_type s);
      wait_idle();
      csr_write(tcm_pkg::REG_MODE_FLAGS, s.mode);
      csr_write(tcm_pkg::REG_RAW_X_LOW, s.x_low);
      csr_write(tcm_pkg::REG_RAW_X_HIGH, s.x_high);
      csr_write(tcm_pkg::REG_RAW_Y_LOW, s.y_low);
      csr_write(tcm_pkg::REG_RAW_Y_HIGH, s.y_high);
      csr_write(tcm_pkg::REG_SCREEN_WIDTH, s.width);
      csr_write(tcm_pkg::REG_SCREEN_HEIGHT, s.height);
      if (s.spare) csr_write(REG_SPARE, csr_data_type'($urandom_range(0, 4095)));
      csr_done();
   endtask

   // Results cannot be held off, so every strobe is checked on the spot.
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected result: mapped_ok %0d screen_x %0d screen_y %0d",
                   rsp_mapped_ok, rsp_screen_x, rsp_screen_y);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_mapped_ok !== want.ok) begin
               $error("mapped_ok: expected %0d, actual %0d", want.ok, rsp_mapped_ok);
               error_count++;
            end
            if (rsp_screen_x !== want.sx) begin
               $error("screen_x: expected %0d, actual %0d", want.sx, rsp_screen_x);
               error_count++;
            end
            if (rsp_screen_y !== want.sy) begin
               $error("screen_y: expected %0d, actual %0d", want.sy, rsp_screen_y);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("touch_coordinate_mapper_core: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      csr_data_type  applied_mode;
      calib_set_type cset;
      raw_type       rx;
      raw_type       ry;
      reset       = 1'b1;
      start       = 1'b0;
      req_raw_x   = '0;
      req_raw_y   = '0;
      csr_we      = 1'b0;
      csr_addr    = '0;
      csr_wdata   = '0;
      error_count = 0;
      idle_cycles = 0;
      burst_mode  = 1'b0;
      calib       = '{mode: '0,
                      x_low: raw_type'(tcm_pkg::RAW_LOW_RST),
                      x_high: raw_type'(tcm_pkg::RAW_HIGH_RST),
                      y_low: raw_type'(tcm_pkg::RAW_LOW_RST),
                      y_high: raw_type'(tcm_pkg::RAW_HIGH_RST),
                      width: screen_type'(tcm_pkg::SCREEN_WIDTH_RST),
                      height: screen_type'(tcm_pkg::SCREEN_HEIGHT_RST)};
      applied_mode = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (touch_rows[i]) begin
         if (touch_rows[i].mode != applied_mode) begin
            wait_idle();
            csr_write(tcm_pkg::REG_MODE_FLAGS, touch_rows[i].mode);
            csr_done();
            applied_mode = touch_rows[i].mode;
         end
         send_touch(touch_rows[i].x, touch_rows[i].y, touch_rows[i].typed,
                    touch_rows[i].res);
      end

      for (int p = 0; p < N_PHASES; p++) begin
         cset = (p < N_FIXED) ? fixed_sets[p] : random_set();
         load_calibration(cset);
         burst_mode = ($urandom_range(0, 2) == 0);
         for (int n = 0; n < SAMPLES_PER_SET; n++) begin
            rx = pick_raw(cset.x_low, cset.x_high);
            ry = pick_raw(cset.y_low, cset.y_high);
            send_touch(rx, ry, 1'b0, '0);
         end
      end

      wait_idle();
      repeat (LATENCY + 5) @(posedge clock);
      if (error_count == 0) begin
         $display("touch_coordinate_mapper_core: match");
      end else begin
         $display("touch_coordinate_mapper_core: mismatch");
      end
      $finish;
   end

endmodule
